// ===== src/nfcacs_pkg.sv =====
// nfcacs_pkg: shared types, codes and constants of the anticollision select sequencer
// used by nfcacs_ctrl, nfcacs_dp and the top level
`timescale 1ns / 1ps

package nfcacs_pkg;

  localparam int LEN_W = 4;
  localparam int IDX_W = 4;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAKE,
    PH_ANTI,
    PH_SEL
  } phase_e;

  typedef enum logic [2:0] {
    SC_WUPA,
    SC_ANTICMD,
    SC_SELECT,
    SC_NEWUID,
    SC_SAME,
    SC_MISS
  } scen_e;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_POLL = 2'd1;
  localparam logic [1:0] KIND_IRQ  = 2'd2;

  localparam logic [1:0] CFG_WAKEUP   = 2'd0;
  localparam logic [1:0] CFG_EXCHANGE = 2'd1;
  localparam logic [1:0] CFG_MISS     = 2'd2;

  localparam logic [3:0] ACT_WUPA    = 4'd0;
  localparam logic [3:0] ACT_PLAIN   = 4'd1;
  localparam logic [3:0] ACT_CRC     = 4'd2;
  localparam logic [3:0] ACT_NEWUID  = 4'd3;
  localparam logic [3:0] ACT_SAME    = 4'd4;
  localparam logic [3:0] ACT_CYCLE   = 4'd5;
  localparam logic [3:0] ACT_FOUND   = 4'd6;
  localparam logic [3:0] ACT_MISSED  = 4'd7;
  localparam logic [3:0] ACT_REMOVED = 4'd8;

  localparam logic [7:0] SEL_CL1   = 8'h93;
  localparam logic [7:0] SEL_CL2   = 8'h95;
  localparam logic [7:0] SEL_CL3   = 8'h97;
  localparam logic [7:0] NVB_ANTI  = 8'h20;
  localparam logic [7:0] NVB_SEL   = 8'h70;
  localparam logic [7:0] CT_BYTE   = 8'h88;
  localparam int         SAK_CASC  = 2;

  localparam logic [15:0] WAKEUP_RST   = 16'd100;
  localparam logic [15:0] EXCHANGE_RST = 16'd200;
  localparam logic [3:0]  MISS_RST     = 4'd10;

  typedef struct packed {
    logic             go;
    logic             emit;
    scen_e            scen;
    logic             set_phase;
    phase_e           phase;
    logic             clr_elapsed;
    logic             lvl_zero;
    logic             lvl_inc;
    logic             uid_clear;
    logic             uid_append;
    logic             fail;
    logic             finish;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    phase_e           phase;
    logic             wake_to;
    logic             exch_to;
    logic             same;
    logic [1:0]       lvl;
    logic [IDX_W-1:0] n;
  } stat_t;

  function automatic logic [7:0] sel_code(input logic [1:0] lvl);
    logic [7:0] r;
    unique case (lvl)
      2'd0:    r = SEL_CL1;
      2'd1:    r = SEL_CL2;
      default: r = SEL_CL3;
    endcase
    return r;
  endfunction

endpackage

// ===== src/nfcacs_ctrl.sv =====
// nfcacs_ctrl: event decoder and result sequencer of the anticollision select block
// depends on nfcacs_pkg, drives nfcacs_dp through cmd_t and reads stat_t
`timescale 1ns / 1ps

module nfcacs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          kind_i,
  input  logic                rx_end_i,
  input  logic                collision_i,
  input  logic                no_response_i,
  input  logic [6:0]          fifo_count_i,
  input  logic [7:0]          rx_byte0_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                last_o,
  input  nfcacs_pkg::stat_t   stat_i,
  output nfcacs_pkg::cmd_t    cmd_o
);
  import nfcacs_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e           state_q;
  logic [IDX_W-1:0] idx_q;
  logic             accept;
  logic             out_xfer;
  logic             is_last;
  logic             run;
  logic             f_rxcol;
  logic             f_nre;
  logic             f_any;
  logic [6:0]       f_fifo;
  logic             do_fail;
  cmd_t             c;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_xfer = (state_q == ST_EMIT) && !out_stall_i;
  assign is_last  = idx_q == (stat_i.n - IDX_W'(1));

  assign f_rxcol = (kind_i == KIND_IRQ) && (rx_end_i || collision_i);
  assign f_nre   = (kind_i == KIND_IRQ) && no_response_i;
  assign f_any   = f_rxcol || f_nre;
  assign f_fifo  = (kind_i == KIND_IRQ) ? fifo_count_i : 7'd0;
  assign run     = (stat_i.phase != PH_IDLE) &&
                   ((kind_i == KIND_TICK) || ((kind_i == KIND_IRQ) && f_any));

  always_comb begin
    c         = '0;
    c.scen    = SC_WUPA;
    c.phase   = PH_IDLE;
    c.go      = accept;
    c.idx     = idx_q;
    do_fail   = 1'b0;
    if (kind_i == KIND_POLL && stat_i.phase == PH_IDLE) begin
      c.emit        = 1'b1;
      c.scen        = SC_WUPA;
      c.set_phase   = 1'b1;
      c.phase       = PH_WAKE;
      c.clr_elapsed = 1'b1;
    end else if (run) begin
      unique case (stat_i.phase)
        PH_WAKE: begin
          if (f_rxcol) begin
            c.emit        = 1'b1;
            c.scen        = SC_ANTICMD;
            c.lvl_zero    = 1'b1;
            c.uid_clear   = 1'b1;
            c.set_phase   = 1'b1;
            c.phase       = PH_ANTI;
            c.clr_elapsed = 1'b1;
          end else if (stat_i.wake_to) begin
            do_fail = 1'b1;
          end
        end
        PH_ANTI: begin
          if (stat_i.exch_to) begin
            do_fail = 1'b1;
          end else if (f_rxcol) begin
            if (f_fifo == 7'd0) begin
              c.emit = 1'b0;
            end else if (f_fifo < 7'd5) begin
              do_fail = 1'b1;
            end else begin
              c.emit        = 1'b1;
              c.scen        = SC_SELECT;
              c.uid_append  = 1'b1;
              c.set_phase   = 1'b1;
              c.phase       = PH_SEL;
              c.clr_elapsed = 1'b1;
            end
          end else if (f_nre) begin
            do_fail = 1'b1;
          end
        end
        PH_SEL: begin
          if (stat_i.exch_to) begin
            do_fail = 1'b1;
          end else if (f_any && f_fifo != 7'd0) begin
            if (rx_byte0_i[SAK_CASC]) begin
              c.lvl_inc = 1'b1;
              if (stat_i.lvl == 2'd2) begin
                do_fail = 1'b1;
              end else begin
                c.emit        = 1'b1;
                c.scen        = SC_ANTICMD;
                c.set_phase   = 1'b1;
                c.phase       = PH_ANTI;
                c.clr_elapsed = 1'b1;
              end
            end else begin
              c.emit      = 1'b1;
              c.scen      = stat_i.same ? SC_SAME : SC_NEWUID;
              c.finish    = 1'b1;
              c.set_phase = 1'b1;
              c.phase     = PH_IDLE;
            end
          end
        end
        default: c.emit = 1'b0;
      endcase
    end
    if (do_fail) begin
      c.emit      = 1'b1;
      c.scen      = SC_MISS;
      c.fail      = 1'b1;
      c.set_phase = 1'b1;
      c.phase     = PH_IDLE;
    end
  end

  assign cmd_o       = c;
  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = state_q == ST_EMIT;
  assign last_o      = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          idx_q <= '0;
          if (accept && c.emit) state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_xfer) begin
            if (is_last) begin
              state_q <= ST_IDLE;
              idx_q   <= '0;
            end else begin
              idx_q <= idx_q + IDX_W'(1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (idx_q < stat_i.n))
    else $error("result index beyond list length");
  a_emit_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while results pending");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && is_last) |=> !out_valid_o)
    else $error("results continue after last transfer");

endmodule

// ===== src/nfcacs_dp.sv =====
// nfcacs_dp: state registers, uid stores, timeout compare and result formatting
// depends on nfcacs_pkg, commanded by nfcacs_ctrl
`timescale 1ns / 1ps

module nfcacs_dp #(
  parameter int UID_MAX_BYTES = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  input  logic [1:0]        kind_i,
  input  logic [7:0]        rx_byte0_i,
  input  logic [7:0]        rx_byte1_i,
  input  logic [7:0]        rx_byte2_i,
  input  logic [7:0]        rx_byte3_i,
  input  logic [7:0]        rx_byte4_i,
  input  nfcacs_pkg::cmd_t  cmd_i,
  output nfcacs_pkg::stat_t stat_o,
  output logic [3:0]        action_o,
  output logic [7:0]        data_byte_o
);
  import nfcacs_pkg::*;

  localparam int IW = (UID_MAX_BYTES > 1) ? $clog2(UID_MAX_BYTES) : 1;
  localparam logic [LEN_W:0] UMAX = (LEN_W + 1)'(UID_MAX_BYTES);

  logic [15:0]      wake_lim_q, exch_lim_q;
  logic [3:0]       miss_lim_q;
  phase_e           phase_q;
  logic [1:0]       lvl_q;
  logic [15:0]      el_q, el_next;
  logic [7:0]       uid_q [UID_MAX_BYTES];
  logic [7:0]       uid_d [UID_MAX_BYTES];
  logic [7:0]       pres_q [UID_MAX_BYTES];
  logic [LEN_W-1:0] ulen_q, ulen_d, plen_q;
  logic             tp_q;
  logic [3:0]       mc_q, mc_inc;
  logic [7:0]       b_q [5];
  logic [7:0]       b_in [5];
  scen_e            scen_q;
  logic [IDX_W-1:0] n_q, n_calc;
  logic             remove;
  logic             same;
  logic             ct;
  logic [7:0]       src [4];
  logic [LEN_W:0]   sum;
  logic [IDX_W-1:0] idx_m1, idx_m2;

  assign b_in[0] = rx_byte0_i;
  assign b_in[1] = rx_byte1_i;
  assign b_in[2] = rx_byte2_i;
  assign b_in[3] = rx_byte3_i;
  assign b_in[4] = rx_byte4_i;

  assign el_next = ((kind_i == KIND_TICK) && (phase_q != PH_IDLE) && (el_q != 16'hFFFF)) ?
                   el_q + 16'd1 : el_q;

  assign mc_inc = (mc_q == 4'd15) ? mc_q : mc_q + 4'd1;
  assign remove = tp_q && (mc_inc >= miss_lim_q);

  always_comb begin
    same = tp_q && (plen_q == ulen_q);
    for (int e = 0; e < UID_MAX_BYTES; e++) begin
      if ((LEN_W + 1)'(e) < {1'b0, ulen_q} && pres_q[e] != uid_q[e]) same = 1'b0;
    end
  end

  // uid append, cascade tag drops the first byte
  always_comb begin
    ct = b_in[0] == CT_BYTE;
    for (int j = 0; j < 4; j++) src[j] = ct ? b_in[(j < 3) ? j + 1 : 3] : b_in[j];
    for (int e = 0; e < UID_MAX_BYTES; e++) begin
      uid_d[e] = uid_q[e];
      for (int j = 0; j < 4; j++) begin
        if ((!ct || j < 3) && ({1'b0, ulen_q} + (LEN_W + 1)'(j)) == (LEN_W + 1)'(e))
          uid_d[e] = src[j];
      end
    end
    sum    = {1'b0, ulen_q} + (ct ? (LEN_W + 1)'(3) : (LEN_W + 1)'(4));
    ulen_d = (sum > UMAX) ? UMAX[LEN_W-1:0] : sum[LEN_W-1:0];
  end

  always_comb begin
    case (cmd_i.scen)
      SC_WUPA:    n_calc = IDX_W'(1);
      SC_ANTICMD: n_calc = IDX_W'(2);
      SC_SELECT:  n_calc = IDX_W'(7);
      SC_NEWUID:  n_calc = IDX_W'(ulen_q) + IDX_W'(2);
      SC_SAME:    n_calc = IDX_W'(3);
      SC_MISS:    n_calc = remove ? IDX_W'(plen_q) + IDX_W'(1) : IDX_W'(1);
      default:    n_calc = IDX_W'(1);
    endcase
  end

  assign stat_o.phase   = phase_q;
  assign stat_o.wake_to = el_next > wake_lim_q;
  assign stat_o.exch_to = el_next > exch_lim_q;
  assign stat_o.same    = same;
  assign stat_o.lvl     = lvl_q;
  assign stat_o.n       = n_q;

  assign idx_m1 = cmd_i.idx - IDX_W'(1);
  assign idx_m2 = cmd_i.idx - IDX_W'(2);

  always_comb begin
    action_o    = ACT_WUPA;
    data_byte_o = 8'd0;
    case (scen_q)
      SC_WUPA: action_o = ACT_WUPA;
      SC_ANTICMD: begin
        action_o    = ACT_PLAIN;
        data_byte_o = (cmd_i.idx == '0) ? sel_code(lvl_q) : NVB_ANTI;
      end
      SC_SELECT: begin
        action_o = ACT_CRC;
        if (cmd_i.idx == '0) data_byte_o = sel_code(lvl_q);
        else if (cmd_i.idx == IDX_W'(1)) data_byte_o = NVB_SEL;
        else data_byte_o = b_q[idx_m2[2:0]];
      end
      SC_NEWUID: begin
        if (cmd_i.idx < IDX_W'(ulen_q)) begin
          action_o    = ACT_NEWUID;
          data_byte_o = uid_q[cmd_i.idx[IW-1:0]];
        end else if (cmd_i.idx == IDX_W'(ulen_q)) begin
          action_o = ACT_CYCLE;
        end else begin
          action_o = ACT_FOUND;
        end
      end
      SC_SAME: begin
        if (cmd_i.idx == '0) action_o = ACT_SAME;
        else if (cmd_i.idx == IDX_W'(1)) action_o = ACT_CYCLE;
        else action_o = ACT_FOUND;
      end
      SC_MISS: begin
        if (cmd_i.idx == '0) begin
          action_o = ACT_MISSED;
        end else begin
          action_o    = ACT_REMOVED;
          data_byte_o = pres_q[idx_m1[IW-1:0]];
        end
      end
      default: action_o = ACT_WUPA;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wake_lim_q <= WAKEUP_RST;
      exch_lim_q <= EXCHANGE_RST;
      miss_lim_q <= MISS_RST;
      phase_q    <= PH_IDLE;
      lvl_q      <= 2'd0;
      el_q       <= 16'd0;
      ulen_q     <= '0;
      plen_q     <= '0;
      tp_q       <= 1'b0;
      mc_q       <= 4'd0;
      scen_q     <= SC_WUPA;
      n_q        <= IDX_W'(1);
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_WAKEUP:   wake_lim_q <= cfg_data_i;
          CFG_EXCHANGE: exch_lim_q <= cfg_data_i;
          CFG_MISS:     miss_lim_q <= cfg_data_i[3:0];
          default:      miss_lim_q <= miss_lim_q;
        endcase
      end
      if (cmd_i.go) begin
        if (cmd_i.set_phase) phase_q <= cmd_i.phase;
        el_q <= cmd_i.clr_elapsed ? 16'd0 : el_next;
        if (cmd_i.lvl_zero) lvl_q <= 2'd0;
        else if (cmd_i.lvl_inc) lvl_q <= lvl_q + 2'd1;
        if (cmd_i.uid_clear) ulen_q <= '0;
        else if (cmd_i.uid_append) ulen_q <= ulen_d;
        if (cmd_i.finish) begin
          mc_q <= 4'd0;
          if (!same) begin
            tp_q   <= 1'b1;
            plen_q <= ulen_q;
          end
        end
        if (cmd_i.fail && tp_q) begin
          if (remove) begin
            tp_q   <= 1'b0;
            plen_q <= '0;
            mc_q   <= 4'd0;
          end else begin
            mc_q <= mc_inc;
          end
        end
        if (cmd_i.emit) begin
          scen_q <= cmd_i.scen;
          n_q    <= n_calc;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.go && cmd_i.uid_append) uid_q <= uid_d;
    if (cmd_i.go && cmd_i.finish && !same) pres_q <= uid_q;
    if (cmd_i.go && cmd_i.emit) b_q <= b_in;
  end

endmodule

// ===== src/nfc_anticollision_select_sequencer_unit.sv =====
// reader-side type A wake-up, anticollision and select sequencer, top level
// one input event (tick, poll, interrupt) is taken while idle; it yields zero to
// fourteen result transfers, one per unstalled cycle, the last flagged by last_o
// input transfer: in_valid_i high and in_stall_o low at a rising edge
// output transfer: out_valid_o high and out_stall_i low at a rising edge
// the first result is offered in the cycle after the input transfer
// an event with no result leaves the input open; the result sequencer in
// nfcacs_ctrl steps through the results of an event
// in_stall_o stays high until the last result of the event has been taken
// a stalled receiver holds the current result and the whole sequence
// reset clears phase, cascade level, counters and lengths and loads the
// default timeouts (100, 200) and miss limit (10)
// configuration writes are taken on any cycle with cfg_we_i high
// depends on nfcacs_pkg, nfcacs_ctrl, nfcacs_dp
`timescale 1ns / 1ps

module nfc_anticollision_select_sequencer_unit #(
  parameter int UID_MAX_BYTES = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic        rx_end_i,
  input  logic        collision_i,
  input  logic        no_response_i,
  input  logic [6:0]  fifo_count_i,
  input  logic [7:0]  rx_byte0_i,
  input  logic [7:0]  rx_byte1_i,
  input  logic [7:0]  rx_byte2_i,
  input  logic [7:0]  rx_byte3_i,
  input  logic [7:0]  rx_byte4_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  action_o,
  output logic [7:0]  data_byte_o,
  output logic        last_o
);
  import nfcacs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  nfcacs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .rx_end_i      (rx_end_i),
    .collision_i   (collision_i),
    .no_response_i (no_response_i),
    .fifo_count_i  (fifo_count_i),
    .rx_byte0_i    (rx_byte0_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .last_o        (last_o),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  nfcacs_dp #(
    .UID_MAX_BYTES (UID_MAX_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .kind_i      (kind_i),
    .rx_byte0_i  (rx_byte0_i),
    .rx_byte1_i  (rx_byte1_i),
    .rx_byte2_i  (rx_byte2_i),
    .rx_byte3_i  (rx_byte3_i),
    .rx_byte4_i  (rx_byte4_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .action_o    (action_o),
    .data_byte_o (data_byte_o)
  );

endmodule
